[sv/sps_pkg.sv]
// sps_pkg: types, codes and widths shared by the sensor poll sequencer
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package sps_pkg;

   localparam int MAX_SENSORS = 16;

   localparam int NOW_W   = 32;
   localparam int RAW_W   = 16;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 5;
   localparam int WAIT_W  = 16;
   localparam int LIMIT_W = 8;
   localparam int FAIL_W  = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_MS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_LIMIT  = 2'd2;

   localparam logic KIND_RUN    = 1'b0;
   localparam logic KIND_SELECT = 1'b1;

   localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

   localparam logic [WAIT_W-1:0]  WAIT_MS_RESET     = 16'd800;
   localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RESET = 8'd3;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_WAIT  = 2'd1,
      PH_READ  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_START = 2'd1,
      ACT_READ  = 2'd2
   } bus_action_type;

   typedef struct packed {
      logic [CNT_W-1:0]   sensor_count;
      logic [WAIT_W-1:0]  wait_ms;
      logic [LIMIT_W-1:0] error_limit;
   } cfg_type;

   typedef struct packed {
      logic                    kind;
      logic [NOW_W-1:0]        now_ms;
      logic                    bus_ok;
      logic signed [RAW_W-1:0] raw_reading;
      logic [IDX_W-1:0]        select_index;
   } req_item_type;

   typedef struct packed {
      bus_action_type          bus_action;
      logic [IDX_W-1:0]        sensor_index;
      logic signed [RAW_W-1:0] temperature;
      logic                    error_flag;
      logic                    has_valid;
      logic                    select_accepted;
   } rsp_item_type;

endpackage

[sv/sps_req_if.sv]
// sps_req_if: request channel of the sensor poll sequencer
// depends on sps_pkg
`timescale 1ns / 1ps

interface sps_req_if import sps_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [NOW_W-1:0]        now_ms;
   logic                    bus_ok;
   logic signed [RAW_W-1:0] raw_reading;
   logic [IDX_W-1:0]        select_index;

   modport source (
      output valid, kind, now_ms, bus_ok, raw_reading, select_index,
      input  ready
   );

   modport sink (
      input  valid, kind, now_ms, bus_ok, raw_reading, select_index,
      output ready
   );

endinterface

[sv/sps_rsp_if.sv]
// sps_rsp_if: response channel of the sensor poll sequencer
// depends on sps_pkg
`timescale 1ns / 1ps

interface sps_rsp_if import sps_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [1:0]              bus_action;
   logic [IDX_W-1:0]        sensor_index;
   logic signed [RAW_W-1:0] temperature;
   logic                    error_flag;
   logic                    has_valid;
   logic                    select_accepted;

   modport source (
      output valid, bus_action, sensor_index, temperature, error_flag, has_valid,
             select_accepted,
      input  ready
   );

   modport sink (
      input  valid, bus_action, sensor_index, temperature, error_flag, has_valid,
             select_accepted,
      output ready
   );

endinterface

[sv/sps_csr.sv]
// sps_csr: configuration registers of the sensor poll sequencer
// depends on sps_pkg
`timescale 1ns / 1ps

module sps_csr import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SENSOR_COUNT: cfg_in.sensor_count = csr_wdata[CNT_W-1:0];
            CSR_WAIT_MS:      cfg_in.wait_ms      = csr_wdata[WAIT_W-1:0];
            CSR_ERROR_LIMIT:  cfg_in.error_limit  = csr_wdata[LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_count <= '0;
         cfg_ff.wait_ms      <= WAIT_MS_RESET;
         cfg_ff.error_limit  <= ERROR_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/sps_seq.sv]
// sps_seq: polling state and the per-request update of the sequencer
// depends on sps_pkg; configuration comes from sps_csr
`timescale 1ns / 1ps

module sps_seq import sps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   phase_type               phase_ff, phase_in;
   logic [NOW_W-1:0]        wait_start_ff, wait_start_in;
   logic [IDX_W-1:0]        selected_ff, selected_in;
   logic signed [RAW_W-1:0] last_temp_ff, last_temp_in;
   logic                    err_flag_ff, err_flag_in;
   logic [FAIL_W-1:0]       fail_count_ff, fail_count_in;
   logic                    valid_seen_ff, valid_seen_in;

   logic [CNT_W-1:0]  eff_count;
   logic              idx_ok;
   logic [NOW_W-1:0]  elapsed;
   logic              wait_done;
   logic [FAIL_W-1:0] fail_next;
   logic              fail_trip;
   bus_action_type    action;
   logic              accepted;

   assign eff_count = (cfg.sensor_count > CNT_W'(MAX_SENSORS)) ?
                      CNT_W'(MAX_SENSORS) : cfg.sensor_count;
   assign idx_ok    = {1'b0, item.select_index} < eff_count;
   assign elapsed   = item.now_ms - wait_start_ff;
   assign wait_done = elapsed >= {{(NOW_W-WAIT_W){1'b0}}, cfg.wait_ms};
   assign fail_next = (fail_count_ff == FAIL_MAX) ? fail_count_ff : fail_count_ff + 1'b1;
   assign fail_trip = fail_next >= cfg.error_limit;

   always_comb begin
      phase_in      = phase_ff;
      wait_start_in = wait_start_ff;
      selected_in   = selected_ff;
      last_temp_in  = last_temp_ff;
      err_flag_in   = err_flag_ff;
      fail_count_in = fail_count_ff;
      valid_seen_in = valid_seen_ff;
      action        = ACT_NONE;
      accepted      = 1'b0;

      if (item.kind == KIND_SELECT) begin
         if (idx_ok) begin
            accepted = 1'b1;
            if (item.select_index != selected_ff) begin
               selected_in   = item.select_index;
               phase_in      = PH_START;
               fail_count_in = '0;
               err_flag_in   = 1'b0;
            end
         end
      end else if (eff_count != '0) begin
         case (phase_ff)
            PH_START: begin
               action = ACT_START;
               if (item.bus_ok) begin
                  wait_start_in = item.now_ms;
                  phase_in      = PH_WAIT;
               end else begin
                  fail_count_in = fail_next;
                  err_flag_in   = err_flag_ff | fail_trip;
               end
            end
            PH_WAIT: begin
               if (wait_done) begin
                  phase_in = PH_READ;
               end
            end
            PH_READ: begin
               action   = ACT_READ;
               phase_in = PH_START;
               if (item.bus_ok) begin
                  last_temp_in  = item.raw_reading;
                  valid_seen_in = 1'b1;
                  fail_count_in = '0;
                  err_flag_in   = 1'b0;
               end else begin
                  fail_count_in = fail_next;
                  err_flag_in   = err_flag_ff | fail_trip;
               end
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end

      result.bus_action      = action;
      result.sensor_index    = selected_in;
      result.temperature     = last_temp_in;
      result.error_flag      = err_flag_in;
      result.has_valid       = valid_seen_in;
      result.select_accepted = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         wait_start_ff <= '0;
         selected_ff   <= '0;
         last_temp_ff  <= '0;
         err_flag_ff   <= 1'b0;
         fail_count_ff <= '0;
         valid_seen_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         wait_start_ff <= wait_start_in;
         selected_ff   <= selected_in;
         last_temp_ff  <= last_temp_in;
         err_flag_ff   <= err_flag_in;
         fail_count_ff <= fail_count_in;
         valid_seen_ff <= valid_seen_in;
      end
   end

endmodule

[sv/sensor_poll_sequencer_core.sv]
// sensor_poll_sequencer_core: top level of the sensor poll sequencer
// depends on sps_pkg, sps_req_if, sps_rsp_if, sps_csr and sps_seq
`timescale 1ns / 1ps

// Takes one request per clock unless the response side stalls, and returns one
// response per request, in order. A request is held in an input register, the
// sequencer state is updated from it and the response is loaded into an output
// register, from which it is offered on the response channel; the input and
// output registers decouple the two channels so that a new request is taken
// whenever the stage ahead moves on. Configuration writes are expected only
// while no request is in flight.

module sensor_poll_sequencer_core import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sps_req_if.sink               req_chan,
   sps_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   req_item_type req_item;
   rsp_item_type step_result;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic out_free;
   logic step_en;

   sps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sps_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign req_item.kind         = req_chan.kind;
   assign req_item.now_ms       = req_chan.now_ms;
   assign req_item.bus_ok       = req_chan.bus_ok;
   assign req_item.raw_reading  = req_chan.raw_reading;
   assign req_item.select_index = req_chan.select_index;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_item_in  = req_item;
      end
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_item_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.bus_action      = out_item_ff.bus_action;
   assign rsp_chan.sensor_index    = out_item_ff.sensor_index;
   assign rsp_chan.temperature     = out_item_ff.temperature;
   assign rsp_chan.error_flag      = out_item_ff.error_flag;
   assign rsp_chan.has_valid       = out_item_ff.has_valid;
   assign rsp_chan.select_accepted = out_item_ff.select_accepted;

endmodule

[sv/sps_checker.sv]
// sps_checker: port-level checks of the sensor poll sequencer, bound to the top level
// depends on sps_pkg and sensor_poll_sequencer_core
`timescale 1ns / 1ps

module sps_checker import sps_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [1:0]              rsp_bus_action,
   input logic [IDX_W-1:0]        rsp_sensor_index,
   input logic signed [RAW_W-1:0] rsp_temperature,
   input logic                    rsp_has_valid,
   input logic                    rsp_select_accepted
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_sensor_index) && $stable(rsp_bus_action))
      else $error("stalled response changed");

   // a taken request is offered as a response when the output is not back-pressured
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 (rsp_ready && !reset) |=> rsp_valid)
      else $error("response missing after request");

   // has_valid never drops between responses
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_has_valid ##1 rsp_valid |-> rsp_has_valid)
      else $error("has_valid dropped");

   // sensor index only changes on an accepted select
   a_index_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 (rsp_valid && !rsp_select_accepted)
         |-> $stable(rsp_sensor_index))
      else $error("sensor index changed without select");

endmodule

bind sensor_poll_sequencer_core sps_checker u_sps_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_bus_action      (rsp_chan.bus_action),
   .rsp_sensor_index    (rsp_chan.sensor_index),
   .rsp_temperature     (rsp_chan.temperature),
   .rsp_has_valid       (rsp_chan.has_valid),
   .rsp_select_accepted (rsp_chan.select_accepted)
);
